[rtl/core/pswf_pkg.sv]
// Shared constants, types and state codes of the pitch slope window filter.
package pswf_pkg;

  localparam int MAX_WINDOW  = 16;
  localparam int SAMPLE_W    = 15;
  localparam int LEN_W       = 5;
  localparam int MODE_W      = 1;
  localparam int THR_W       = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;
  localparam int OUT_W       = 15;
  localparam int POS_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W       = SAMPLE_W + POS_W;
  localparam int MAG_W       = SUM_W;
  localparam int SCALE_W     = 24;
  localparam int SCALE_SHIFT = 24;
  localparam int PROD_W      = MAG_W + SCALE_W;
  localparam int QUO_W       = PROD_W - SCALE_SHIFT;
  localparam int DIV_STEPS   = (QUO_W + 1) / 2;
  localparam int DIV_W       = 2 * DIV_STEPS;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int RES_W       = 14;

  // About 2^24 * 180 * 128 / (pi * 8192): Q2.13 radians to Q8.7 degrees.
  localparam logic [SCALE_W-1:0] DEG_SCALE = 24'd15019745;
  localparam logic [RES_W-1:0]   OUT_LIMIT = 14'd11520;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_index_t;

  localparam cfg_index_t CFG_WINDOW_LENGTH = 2'd0;
  localparam cfg_index_t CFG_FILTER_MODE   = 2'd1;
  localparam cfg_index_t CFG_DEADBAND      = 2'd2;

  localparam logic [MODE_W-1:0] MODE_MEDIAN = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROTATE,
    ST_SELECT,
    ST_MULT,
    ST_ROUND,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] below;
    logic [CNT_W-1:0] upto;
  } cell_count_t;

endpackage

[rtl/core/pswf_channels.sv]
// Handshake channels of the filter: sample input, slope output, register writes.
interface pswf_sample_if;
  logic                  valid;
  logic                  ready;
  pswf_pkg::sample_t     pitch_sample;
  modport source (output valid, output pitch_sample, input ready);
  modport sink (input valid, input pitch_sample, output ready);
endinterface

interface pswf_slope_if;
  logic                         valid;
  logic                         ready;
  logic [pswf_pkg::OUT_W-1:0]   slope_degrees;
  modport source (output valid, output slope_degrees, input ready);
  modport sink (input valid, input slope_degrees, output ready);
endinterface

interface pswf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pswf_pkg::CFG_IDX_W-1:0]    index;
  logic [pswf_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/pswf_cell.sv]
// One window cell: holds a sample, passes a circulating probe and ranks against it.
module pswf_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  pswf_pkg::cell_ctrl_t  ctrl,
  input  logic                  active,
  input  pswf_pkg::sample_t     samp_in,
  input  pswf_pkg::sample_t     probe_in,
  input  logic                  probe_act_in,
  output pswf_pkg::sample_t     samp,
  output pswf_pkg::sample_t     probe,
  output logic                  probe_act,
  output pswf_pkg::cell_count_t count
);

  always_ff @(posedge clk) begin
    if (rst) begin
      samp      <= '0;
      probe     <= '0;
      probe_act <= 1'b0;
      count     <= '0;
    end else begin
      if (ctrl.shift) begin
        samp <= samp_in;
      end
      if (ctrl.load) begin
        probe     <= samp;
        probe_act <= active;
        count     <= '0;
      end else if (ctrl.rotate) begin
        probe     <= probe_in;
        probe_act <= probe_act_in;
        // Only probes that came from cells inside the window are counted.
        if (probe_act) begin
          if (probe < samp) begin
            count.below <= count.below + 1'b1;
          end
          if (probe <= samp) begin
            count.upto <= count.upto + 1'b1;
          end
        end
      end
    end
  end

endmodule

[rtl/core/pswf_div.sv]
// Restoring divider by the window length (by one in median mode), two quotient bits per cycle.
module pswf_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pswf_pkg::QUO_W-1:0]  dividend,
  input  logic [pswf_pkg::LEN_W-1:0]  divisor,
  output logic                        done,
  output logic [pswf_pkg::DIV_W-1:0]  quotient
);

  logic [pswf_pkg::LEN_W-1:0]  rem;
  logic [pswf_pkg::LEN_W-1:0]  rem_next;
  logic [pswf_pkg::DIV_W-1:0]  quo_next;
  logic [pswf_pkg::STEP_W-1:0] step_cnt;
  logic                        running;
  logic [pswf_pkg::LEN_W:0]    trial_a;
  logic [pswf_pkg::LEN_W:0]    trial_b;
  logic [pswf_pkg::LEN_W:0]    diff_a;
  logic [pswf_pkg::LEN_W:0]    diff_b;
  logic                        bit_a;
  logic                        bit_b;
  logic [pswf_pkg::LEN_W-1:0]  rem_a;

  always_comb begin
    trial_a  = {rem, quotient[pswf_pkg::DIV_W-1]};
    bit_a    = trial_a >= {1'b0, divisor};
    diff_a   = trial_a - {1'b0, divisor};
    rem_a    = bit_a ? diff_a[pswf_pkg::LEN_W-1:0] : trial_a[pswf_pkg::LEN_W-1:0];
    trial_b  = {rem_a, quotient[pswf_pkg::DIV_W-2]};
    bit_b    = trial_b >= {1'b0, divisor};
    diff_b   = trial_b - {1'b0, divisor};
    rem_next = bit_b ? diff_b[pswf_pkg::LEN_W-1:0] : trial_b[pswf_pkg::LEN_W-1:0];
    quo_next = {quotient[pswf_pkg::DIV_W-3:0], bit_a, bit_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
      rem      <= '0;
      quotient <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        step_cnt <= '0;
        rem      <= '0;
        quotient <= {{(pswf_pkg::DIV_W - pswf_pkg::QUO_W){1'b0}}, dividend};
      end else if (running) begin
        rem      <= rem_next;
        quotient <= quo_next;
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == pswf_pkg::STEP_W'(pswf_pkg::DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/pitch_slope_window_filter.sv]
// Sequence: an accepted word is loaded into the probes and rotated through the cell chain,
// then passes select, multiply, round, the divider's two-bit steps and its done flag,
// and finish, where its slope is registered for the output.
// A new word is taken only in idle, once the previous word has left finish; the next
// word is taken while a finished slope still waits, and a stalled output holds the finish.
// Reset (rst, synchronous): window cleared to zeros, length 5, median mode, no deadband.
module pitch_slope_window_filter (
  input  logic       clk,
  input  logic       rst,
  pswf_sample_if.sink  sample,
  pswf_slope_if.source slope,
  pswf_cfg_if.sink     cfg
);

  localparam int N = pswf_pkg::MAX_WINDOW;

  pswf_pkg::state_t state;
  pswf_pkg::state_t state_next;

  logic [pswf_pkg::LEN_W-1:0]  window_length;
  logic [pswf_pkg::MODE_W-1:0] filter_mode;
  logic [pswf_pkg::THR_W-1:0]  deadband_threshold;

  pswf_pkg::cell_ctrl_t        cell_ctrl;
  pswf_pkg::sample_t           cell_samp [N];
  pswf_pkg::sample_t           cell_probe [N];
  logic                        cell_probe_act [N];
  pswf_pkg::cell_count_t       cell_count [N];
  logic [N-1:0]                cell_active;
  logic [N-1:0]                cell_hit;

  logic [pswf_pkg::CNT_W-1:0]  eff_len;
  logic [pswf_pkg::CNT_W-1:0]  rank;
  logic [pswf_pkg::LEN_W-1:0]  divisor;
  logic [pswf_pkg::POS_W-1:0]  rot_cnt;
  logic signed [pswf_pkg::SUM_W-1:0] window_sum;
  pswf_pkg::sample_t           median;
  logic [pswf_pkg::MAG_W-1:0]  mag;
  logic [pswf_pkg::MAG_W-1:0]  mag_next;
  logic                        negative;
  logic                        negative_next;
  logic [pswf_pkg::PROD_W-1:0] num;
  logic [pswf_pkg::PROD_W-1:0] rounded;
  logic                        div_start;
  logic                        div_done;
  logic [pswf_pkg::DIV_W-1:0]  quotient;
  logic [pswf_pkg::RES_W-1:0]  sat;
  logic [pswf_pkg::RES_W-1:0]  result;
  logic [pswf_pkg::OUT_W-1:0]  slope_next;
  logic                        out_load;
  logic                        out_valid;
  logic [pswf_pkg::OUT_W-1:0]  slope_reg;

  // Register writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length      <= pswf_pkg::LEN_W'(5);
      filter_mode        <= pswf_pkg::MODE_MEDIAN;
      deadband_threshold <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        pswf_pkg::CFG_WINDOW_LENGTH: window_length <= cfg.data[pswf_pkg::LEN_W-1:0];
        pswf_pkg::CFG_FILTER_MODE:   filter_mode <= cfg.data[pswf_pkg::MODE_W-1:0];
        pswf_pkg::CFG_DEADBAND:      deadband_threshold <= cfg.data[pswf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero length acts as one; lengths beyond the chain act as the full chain.
  always_comb begin
    if (window_length == '0) begin
      eff_len = pswf_pkg::CNT_W'(1);
    end else if (pswf_pkg::CNT_W'(window_length) > pswf_pkg::CNT_W'(N)) begin
      eff_len = pswf_pkg::CNT_W'(N);
    end else begin
      eff_len = pswf_pkg::CNT_W'(window_length);
    end
    rank    = eff_len >> 1;
    divisor = (filter_mode == pswf_pkg::MODE_MEDIAN) ? pswf_pkg::LEN_W'(1)
                                                     : pswf_pkg::LEN_W'(eff_len);
  end

  // Cell chain: cell 0 holds the newest sample; probes circulate toward cell 0.
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign cell_active[i] = pswf_pkg::CNT_W'(i) < eff_len;
    assign cell_hit[i]    = cell_active[i] && (cell_count[i].below <= rank)
                            && (rank < cell_count[i].upto);

    pswf_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (cell_ctrl),
      .active       (cell_active[i]),
      .samp_in      ((i == 0) ? sample.pitch_sample : cell_samp[(i + N - 1) % N]),
      .probe_in     (cell_probe[(i + 1) % N]),
      .probe_act_in (cell_probe_act[(i + 1) % N]),
      .samp         (cell_samp[i]),
      .probe        (cell_probe[i]),
      .probe_act    (cell_probe_act[i]),
      .count        (cell_count[i])
    );
  end

  // Every hit cell holds the same value, so the hits can simply be merged.
  always_comb begin
    median = '0;
    for (int i = 0; i < N; i++) begin
      if (cell_hit[i]) begin
        median = median | cell_samp[i];
      end
    end
  end

  always_comb begin
    if (filter_mode == pswf_pkg::MODE_MEDIAN) begin
      negative_next = median[pswf_pkg::SAMPLE_W-1];
      mag_next      = {{(pswf_pkg::MAG_W - pswf_pkg::SAMPLE_W){median[pswf_pkg::SAMPLE_W-1]}},
                       median};
    end else begin
      negative_next = window_sum[pswf_pkg::SUM_W-1];
      mag_next      = window_sum;
    end
    if (negative_next) begin
      mag_next = -mag_next;
    end
  end

  assign rounded = num + (pswf_pkg::PROD_W'(divisor) << (pswf_pkg::SCALE_SHIFT - 1));

  pswf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rounded[pswf_pkg::PROD_W-1:pswf_pkg::SCALE_SHIFT]),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    if (quotient > pswf_pkg::DIV_W'(pswf_pkg::OUT_LIMIT)) begin
      sat = pswf_pkg::OUT_LIMIT;
    end else begin
      sat = quotient[pswf_pkg::RES_W-1:0];
    end
    result = (sat < deadband_threshold) ? '0 : sat;
    // A positive pitch reads as a negative slope.
    if (!negative && (result != '0)) begin
      slope_next = -pswf_pkg::OUT_W'(result);
    end else begin
      slope_next = pswf_pkg::OUT_W'(result);
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      pswf_pkg::ST_IDLE:   if (sample.valid) state_next = pswf_pkg::ST_LOAD;
      pswf_pkg::ST_LOAD:   state_next = pswf_pkg::ST_ROTATE;
      pswf_pkg::ST_ROTATE: begin
        if (rot_cnt == pswf_pkg::POS_W'(N - 1)) state_next = pswf_pkg::ST_SELECT;
      end
      pswf_pkg::ST_SELECT: state_next = pswf_pkg::ST_MULT;
      pswf_pkg::ST_MULT:   state_next = pswf_pkg::ST_ROUND;
      pswf_pkg::ST_ROUND:  state_next = pswf_pkg::ST_DIVIDE;
      pswf_pkg::ST_DIVIDE: if (div_done) state_next = pswf_pkg::ST_FINISH;
      pswf_pkg::ST_FINISH: if (out_load) state_next = pswf_pkg::ST_IDLE;
      default:             state_next = pswf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sample.ready     = 1'b0;
    cell_ctrl        = '0;
    div_start        = 1'b0;
    out_load         = 1'b0;
    case (state)
      pswf_pkg::ST_IDLE: begin
        sample.ready    = 1'b1;
        cell_ctrl.shift = sample.valid;
      end
      pswf_pkg::ST_LOAD:   cell_ctrl.load = 1'b1;
      pswf_pkg::ST_ROTATE: cell_ctrl.rotate = 1'b1;
      pswf_pkg::ST_ROUND:  div_start = 1'b1;
      pswf_pkg::ST_FINISH: out_load = !out_valid || slope.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pswf_pkg::ST_IDLE;
      rot_cnt    <= '0;
      window_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pswf_pkg::ST_LOAD) begin
        rot_cnt    <= '0;
        window_sum <= '0;
      end else if (state == pswf_pkg::ST_ROTATE) begin
        rot_cnt <= rot_cnt + 1'b1;
        // Each probe passes cell 0 once during the rotation.
        if (cell_probe_act[0]) begin
          window_sum <= window_sum + pswf_pkg::SUM_W'(cell_probe[0]);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (slope.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pswf_pkg::ST_SELECT) begin
      mag      <= mag_next;
      negative <= negative_next;
    end
    if (state == pswf_pkg::ST_MULT) begin
      num <= pswf_pkg::PROD_W'(mag) * pswf_pkg::PROD_W'(pswf_pkg::DEG_SCALE);
    end
    if (out_load) begin
      slope_reg <= slope_next;
    end
  end

  assign slope.valid         = out_valid;
  assign slope.slope_degrees = slope_reg;

endmodule
